/* rtl/core/sia_pkg.sv */
// Shared types and constants for the slot index allocator.
// Holds codes, field widths and the control structs between the top level and its free FIFO.
// Depends on nothing.
package sia_pkg;

    localparam int unsigned SLOT_IDX_W   = 10;
    localparam int unsigned SLOT_SPACE   = 2 ** SLOT_IDX_W;
    localparam int unsigned LIMIT_W      = 11;
    localparam int unsigned STATUS_W     = 2;
    localparam int unsigned APB_DATA_W   = 32;
    localparam int unsigned APB_ADDR_W   = 3;

    localparam logic [LIMIT_W-1:0] SLOT_LIMIT_RESET = 11'd1024;

    // register index, taken from paddr above the byte offset
    localparam logic REG_SLOT_LIMIT = 1'b0;

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_ALLOCATED = 2'd0,
        STAT_QUEUED    = 2'd1,
        STAT_DUPLICATE = 2'd2,
        STAT_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic                  push;
        logic                  pop;
        logic [SLOT_IDX_W-1:0] push_data;
    } t_fifo_req;

    typedef struct packed {
        logic                  empty;
        logic [SLOT_IDX_W-1:0] head_data;
    } t_fifo_stat;

endpackage

/* rtl/core/sia_free_fifo.sv */
// Ring FIFO of released slot indices, kept in a synchronous memory.
// Depends on sia_pkg for the request and status structs.
module sia_free_fifo #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sia_pkg::t_fifo_req  i_req,
    output sia_pkg::t_fifo_stat o_stat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(DEPTH - 1);

    logic [sia_pkg::SLOT_IDX_W-1:0] r_mem [DEPTH];
    logic [sia_pkg::SLOT_IDX_W-1:0] r_head_data;
    logic [PTR_W-1:0]               r_head;
    logic [PTR_W-1:0]               r_tail;
    logic [CNT_W-1:0]               r_count;
    logic [PTR_W-1:0]               n_head;
    logic [PTR_W-1:0]               n_tail;
    logic [CNT_W-1:0]               n_count;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_req.pop) begin
            n_head = (r_head == LAST_POS) ? '0 : r_head + PTR_W'(1);
        end
        if (i_req.push) begin
            n_tail = (r_tail == LAST_POS) ? '0 : r_tail + PTR_W'(1);
        end
        case ({i_req.push, i_req.pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // write at the tail
    always_ff @(posedge i_clk) begin
        if (i_req.push) begin
            r_mem[r_tail] <= i_req.push_data;
        end
    end

    // read the head entry every cycle into a registered output
    always_ff @(posedge i_clk) begin
        r_head_data <= r_mem[r_head];
    end

    assign o_stat.empty     = (r_count == '0);
    assign o_stat.head_data = r_head_data;

endmodule

/* rtl/core/slot_index_allocator_unit.sv */
// Slot index allocator: hands out slot indices, reusing released indices first (oldest first)
// and falling back to a bump counter below a programmable limit when none wait. Each item has
// a read step, the synchronous reads of the presence memory and of the FIFO head entry, and a
// decide step that writes both memories back and loads the result register. The next item is
// accepted while a result still waits in the output register; an item in its decide step holds
// only while that register is occupied and the result channel stalls. After reset, a clearing
// pass over all min(MAX_SLOTS, 1024) entries zeroes the presence memory; no transfer is
// accepted during it, while register writes are. Depends on sia_pkg and sia_free_fifo.
module slot_index_allocator_unit #(
    parameter int unsigned MAX_SLOTS = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_req_type,
    input  logic [sia_pkg::SLOT_IDX_W-1:0]     i_slot_index,
    // result channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [sia_pkg::SLOT_IDX_W-1:0]     o_granted_index,
    output logic [sia_pkg::STATUS_W-1:0]       o_status,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sia_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [sia_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [sia_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    // Only indices below the 10-bit index space can ever be released, so the presence memory
    // and the ring need no more entries than that.
    localparam int unsigned PRES_DEPTH =
        (MAX_SLOTS < sia_pkg::SLOT_SPACE) ? MAX_SLOTS : sia_pkg::SLOT_SPACE;
    localparam int unsigned PRES_W = $clog2(PRES_DEPTH);
    localparam logic [PRES_W-1:0] PRES_LAST = PRES_W'(PRES_DEPTH - 1);

    sia_pkg::t_state      r_state;
    sia_pkg::t_state      n_state;
    logic [PRES_W-1:0]    r_clr_addr;

    // configuration
    logic [sia_pkg::LIMIT_W-1:0] r_slot_limit;
    logic                        cfg_write;

    // captured request
    logic                          r_req_type;
    logic [sia_pkg::SLOT_IDX_W-1:0] r_idx;

    // presence memory: one bit per slot, set while the slot waits in the FIFO
    logic                r_presence_mem [PRES_DEPTH];
    logic                r_pres_rd;
    logic                pres_we;
    logic [PRES_W-1:0]   pres_wa;
    logic                pres_wd;

    // bump counter
    logic [sia_pkg::LIMIT_W-1:0] r_next_fresh;
    logic [sia_pkg::LIMIT_W-1:0] n_next_fresh;
    logic                        fresh_ok;
    logic                        idx_in_range;

    // result register
    logic                           r_out_valid;
    logic [sia_pkg::SLOT_IDX_W-1:0] r_granted;
    sia_pkg::t_status               r_status;
    logic [sia_pkg::SLOT_IDX_W-1:0] n_granted;
    sia_pkg::t_status               n_status;

    logic in_xfer;
    logic out_xfer;
    logic exec_go;

    sia_pkg::t_fifo_req  fifo_req;
    sia_pkg::t_fifo_stat fifo_stat;

    // ---------------------------------------------------------------- configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[2] == sia_pkg::REG_SLOT_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_limit <= sia_pkg::SLOT_LIMIT_RESET;
        end else if (cfg_write) begin
            r_slot_limit <= pwdata[sia_pkg::LIMIT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == sia_pkg::REG_SLOT_LIMIT) begin
            prdata = sia_pkg::APB_DATA_W'(r_slot_limit);
        end
    end

    // ---------------------------------------------------------------- handshakes
    assign o_stall  = (r_state != sia_pkg::ST_IDLE);
    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = r_out_valid && !i_stall;
    // finish an item only when the result register is free or being drained
    assign exec_go  = (r_state == sia_pkg::ST_EXEC) && (!r_out_valid || !i_stall);

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sia_pkg::ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == sia_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + PRES_W'(1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sia_pkg::ST_CLEAR: begin
                if (r_clr_addr == PRES_LAST) begin
                    n_state = sia_pkg::ST_IDLE;
                end
            end
            sia_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_state = sia_pkg::ST_EXEC;
                end
            end
            sia_pkg::ST_EXEC: begin
                if (exec_go) begin
                    n_state = sia_pkg::ST_IDLE;
                end
            end
            default: n_state = sia_pkg::ST_IDLE;
        endcase
    end

    // capture the request payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_req_type <= i_req_type;
            r_idx      <= i_slot_index;
        end
    end

    // ---------------------------------------------------------------- decision
    // Effective limit saturates at MAX_SLOTS; a lowered limit simply stops fresh grants.
    assign fresh_ok = ((32'(r_slot_limit) > MAX_SLOTS) ? (32'(r_next_fresh) < MAX_SLOTS)
                                                       : (r_next_fresh < r_slot_limit));
    assign idx_in_range = (32'(r_idx) < MAX_SLOTS);

    always_comb begin
        n_granted          = '0;
        n_status           = sia_pkg::STAT_FULL;
        n_next_fresh       = r_next_fresh;
        fifo_req.push      = 1'b0;
        fifo_req.pop       = 1'b0;
        fifo_req.push_data = r_idx;
        pres_we            = 1'b0;
        pres_wa            = r_clr_addr;
        pres_wd            = 1'b0;

        if (r_state == sia_pkg::ST_CLEAR) begin
            pres_we = 1'b1;
        end else if (exec_go) begin
            if (r_req_type == sia_pkg::REQ_ALLOC) begin
                if (!fifo_stat.empty) begin
                    // reuse the oldest released index and drop its presence bit
                    n_granted    = fifo_stat.head_data;
                    n_status     = sia_pkg::STAT_ALLOCATED;
                    fifo_req.pop = 1'b1;
                    pres_we      = 1'b1;
                    pres_wa      = fifo_stat.head_data[PRES_W-1:0];
                    pres_wd      = 1'b0;
                end else if (fresh_ok) begin
                    n_granted    = r_next_fresh[sia_pkg::SLOT_IDX_W-1:0];
                    n_status     = sia_pkg::STAT_ALLOCATED;
                    n_next_fresh = r_next_fresh + sia_pkg::LIMIT_W'(1);
                end else begin
                    n_status = sia_pkg::STAT_FULL;
                end
            end else begin
                if (!idx_in_range || r_pres_rd) begin
                    n_status = sia_pkg::STAT_DUPLICATE;
                end else begin
                    n_status      = sia_pkg::STAT_QUEUED;
                    fifo_req.push = 1'b1;
                    pres_we       = 1'b1;
                    pres_wa       = r_idx[PRES_W-1:0];
                    pres_wd       = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_fresh <= '0;
        end else begin
            r_next_fresh <= n_next_fresh;
        end
    end

    // ---------------------------------------------------------------- presence memory
    always_ff @(posedge i_clk) begin
        if (pres_we) begin
            r_presence_mem[pres_wa] <= pres_wd;
        end
    end

    // read at acceptance; the registered value is held for the decide step
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_pres_rd <= r_presence_mem[i_slot_index[PRES_W-1:0]];
        end
    end

    // ---------------------------------------------------------------- free FIFO
    sia_free_fifo #(
        .DEPTH (PRES_DEPTH)
    ) u_free_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fifo_req),
        .o_stat  (fifo_stat)
    );

    // ---------------------------------------------------------------- result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_go) begin
            r_out_valid <= 1'b1;
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_go) begin
            r_granted <= n_granted;
            r_status  <= n_status;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_granted_index = r_granted;
    assign o_status        = r_status;

endmodule

/* tb/slot_alloc_check_pkg.sv */
`timescale 1ns / 100ps
// Scoreboard for the slot index allocator: tracks the free list, bump counter and limit,
// and matches each granted index and status against the oldest pending prediction.
// Depends on sia_pkg.
package slot_alloc_check_pkg;

    import sia_pkg::*;

    typedef struct packed {
        logic [SLOT_IDX_W-1:0] granted;
        t_status               status;
    } t_grant_result;

    class slot_alloc_scoreboard;

        logic [LIMIT_W-1:0]    limit_reg;
        logic [LIMIT_W-1:0]    fresh_ctr;
        logic [SLOT_IDX_W-1:0] free_ring[$];
        bit                    in_ring[SLOT_SPACE];
        // indices currently handed out and not yet returned
        logic [SLOT_IDX_W-1:0] held[$];
        t_grant_result         awaited[$];
        int unsigned           errors;

        function new();
            limit_reg = SLOT_LIMIT_RESET;
            fresh_ctr = '0;
            errors    = 0;
            foreach (in_ring[i]) in_ring[i] = 1'b0;
        endfunction

        function void set_limit(logic [LIMIT_W-1:0] value);
            limit_reg = value;
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        function void note_request(logic req, logic [SLOT_IDX_W-1:0] idx);
            t_grant_result         res;
            logic [LIMIT_W-1:0]    eff_limit;
            logic [SLOT_IDX_W-1:0] reused;
            res = '{granted: '0, status: STAT_FULL};
            if (req == REQ_ALLOC) begin
                eff_limit = (limit_reg > SLOT_SPACE) ? LIMIT_W'(SLOT_SPACE) : limit_reg;
                if (free_ring.size() > 0) begin
                    reused = free_ring[0];
                    free_ring.delete(0);
                    in_ring[reused] = 1'b0;
                    held.insert(held.size(), reused);
                    res = '{granted: reused, status: STAT_ALLOCATED};
                end else if (fresh_ctr < eff_limit) begin
                    held.insert(held.size(), fresh_ctr[SLOT_IDX_W-1:0]);
                    res = '{granted: fresh_ctr[SLOT_IDX_W-1:0], status: STAT_ALLOCATED};
                    fresh_ctr = fresh_ctr + LIMIT_W'(1);
                end
            end else if (in_ring[idx]) begin
                res.status = STAT_DUPLICATE;
            end else begin
                free_ring.insert(free_ring.size(), idx);
                in_ring[idx] = 1'b1;
                for (int i = 0; i < held.size(); i++) begin
                    if (held[i] == idx) begin
                        held.delete(i);
                        break;
                    end
                end
                res.status = STAT_QUEUED;
            end
            awaited.insert(awaited.size(), res);
        endfunction

        function void check_result(logic [SLOT_IDX_W-1:0] granted, logic [STATUS_W-1:0] status);
            t_grant_result want;
            if (awaited.size() == 0) begin
                $error("result transfer with nothing pending: granted_index %0d, status %0d",
                       granted, status);
                errors++;
            end else begin
                want = awaited[0];
                awaited.delete(0);
                if (granted !== want.granted) begin
                    $error("granted_index: expected %0d, actual %0d", want.granted, granted);
                    errors++;
                end
                if (status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    errors++;
                end
            end
        endfunction

    endclass

endpackage

/* tb/tb_slot_index_allocator_unit.sv */
`timescale 1ns / 100ps
// Top-level testbench for slot_index_allocator_unit: directed and random allocate/release
// traffic across several slot limits, with random gaps and stalls on both channels.
// Depends on sia_pkg, slot_alloc_check_pkg and the allocator RTL.
module tb_slot_index_allocator_unit;

    import sia_pkg::*;
    import slot_alloc_check_pkg::*;

    // clearing pass after reset plus every item with its random gaps and stalls, taken many times over
    localparam int unsigned CYCLE_LIMIT = 600_000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                  i_valid;
    logic                  o_stall;
    logic                  i_req_type;
    logic [SLOT_IDX_W-1:0] i_slot_index;

    logic                  o_valid;
    logic                  i_stall;
    logic [SLOT_IDX_W-1:0] o_granted_index;
    logic [STATUS_W-1:0]   o_status;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    slot_alloc_scoreboard sb;
    int unsigned          cycle_count = 0;
    // when set, both sides run back to back with no gaps or stalls
    bit                   no_idle = 1'b0;

    slot_index_allocator_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_req_type      (i_req_type),
        .i_slot_index    (i_slot_index),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_granted_index (o_granted_index),
        .o_status        (o_status),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #5 i_clk = ~i_clk;

    // Hard stop in case a handshake never completes.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** slot_index_allocator_unit: FAILED **");
            $finish;
        end
    end

    // Sample the result channel at the edge; any completed transfer goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result(o_granted_index, o_status);
        end
    end

    function automatic int unsigned idle_draw();
        return no_idle ? 0 : $urandom_range(0, 19);
    endfunction

    // Result side: hold stall for a random number of cycles, then release it until one
    // transfer completes, and draw again.
    initial begin
        int unsigned hold_cycles;
        i_stall <= 1'b0;
        forever begin
            hold_cycles = idle_draw();
            if (hold_cycles > 0) begin
                i_stall <= 1'b1;
                repeat (hold_cycles) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(i_rst_n && o_valid));
        end
    end

    // Drive one request: optional gap, then hold valid and payload until the block takes it.
    // The prediction is made at the accepting edge so the scoreboard state always matches
    // what the block has seen.
    task automatic issue_request(input logic req, input logic [SLOT_IDX_W-1:0] idx);
        int unsigned gap;
        gap = idle_draw();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_req_type   <= req;
        i_slot_index <= idx;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(req, idx);
    endtask

    // Drain everything in flight, then program the slot limit with a setup and an access phase.
    task automatic program_limit(input logic [LIMIT_W-1:0] value);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_SLOT_LIMIT, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_limit(value);
    endtask

    // Random traffic. Most items are well formed: allocates, and releases of indices that
    // are currently held. The rest is noise: releases of arbitrary indices (held, never
    // allocated or duplicates), re-releases of indices already waiting in the free list and
    // extra allocates. Stop early once the bump counter is exhausted when fill_counter is set.
    task automatic run_traffic(input int unsigned n_items, input int unsigned alloc_pct,
                               input int unsigned noise_pct, input bit fill_counter);
        int unsigned           pick;
        logic [SLOT_IDX_W-1:0] idx;
        for (int unsigned n = 0; n < n_items; n++) begin
            if (fill_counter && sb.fresh_ctr >= SLOT_SPACE) break;
            // alternate stretches with and without gaps
            if (n % 48 == 0) no_idle = ($urandom_range(0, 3) == 0);
            idx = SLOT_IDX_W'($urandom_range(0, SLOT_SPACE - 1));
            if ($urandom_range(0, 99) < noise_pct) begin
                pick = $urandom_range(0, 2);
                if (pick == 0) begin
                    issue_request(REQ_RELEASE, idx);
                end else if (pick == 1 && sb.free_ring.size() > 0) begin
                    issue_request(REQ_RELEASE,
                                  sb.free_ring[$urandom_range(0, sb.free_ring.size() - 1)]);
                end else begin
                    issue_request(REQ_ALLOC, idx);
                end
            end else if ($urandom_range(0, 99) < alloc_pct || sb.held.size() == 0) begin
                issue_request(REQ_ALLOC, idx);
            end else begin
                issue_request(REQ_RELEASE, sb.held[$urandom_range(0, sb.held.size() - 1)]);
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        sb = new();
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_req_type   <= REQ_ALLOC;
        i_slot_index <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Tiny limit: exhaust the counter, then reuse freed slots while it stays exhausted.
        // The write lands during the clearing pass, which the port allows.
        program_limit(LIMIT_W'(3));
        issue_request(REQ_ALLOC, 10'h3FF);     // index field ignored on allocate
        issue_request(REQ_ALLOC, 10'h000);
        issue_request(REQ_ALLOC, 10'h155);
        issue_request(REQ_ALLOC, 10'h000);     // counter at limit, list empty: full
        issue_request(REQ_RELEASE, 10'h3FF);   // never allocated, still queued
        issue_request(REQ_RELEASE, 10'h000);
        issue_request(REQ_RELEASE, 10'h000);   // already queued: duplicate
        issue_request(REQ_RELEASE, 10'h3FF);   // duplicate
        issue_request(REQ_ALLOC, 10'h000);     // reuse oldest despite exhausted counter
        issue_request(REQ_ALLOC, 10'h000);
        issue_request(REQ_ALLOC, 10'h000);     // full again
        issue_request(REQ_RELEASE, 10'h2AA);
        issue_request(REQ_RELEASE, 10'h155);
        issue_request(REQ_ALLOC, 10'h2AA);
        issue_request(REQ_ALLOC, 10'h155);

        // Zero limit: only queued slots can be handed out.
        program_limit(LIMIT_W'(0));
        issue_request(REQ_ALLOC, 10'h000);
        issue_request(REQ_RELEASE, 10'h002);
        issue_request(REQ_ALLOC, 10'h000);
        issue_request(REQ_ALLOC, 10'h000);

        // Limit beyond the slot space; counter resumes where it stopped.
        program_limit(LIMIT_W'(2047));
        issue_request(REQ_ALLOC, 10'h000);

        // Random phases, mostly with rising limits since the counter never goes back.
        program_limit(LIMIT_W'(1));
        run_traffic(50, 55, 10, 1'b0);
        program_limit(LIMIT_W'(48));
        run_traffic(100, 60, 10, 1'b0);
        program_limit(LIMIT_W'(0));
        run_traffic(40, 50, 10, 1'b0);
        // Full slot space: allocate-heavy until the counter reaches the end.
        program_limit(SLOT_LIMIT_RESET);
        run_traffic(1400, 97, 2, 1'b1);
        // Oversized limit must saturate; release-heavy to build a deep free list.
        program_limit(LIMIT_W'(2047));
        run_traffic(120, 30, 10, 1'b0);
        // Lower the limit well below the counter; only reuse can succeed.
        program_limit(LIMIT_W'(700));
        run_traffic(60, 55, 10, 1'b0);

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("** slot_index_allocator_unit: PASSED **");
        end else begin
            $display("** slot_index_allocator_unit: FAILED **");
        end
        $finish;
    end

endmodule
